[hdl/bgc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Button gesture classifier package
// Shared request types, configuration record, event codes and register map.
// ----------------------------------------------------------------------------
package bgc_pkg;

    localparam int CFG_BITS  = 16;
    localparam int DUR_BITS  = 16;
    localparam int IDX_BITS  = 3;

    localparam logic [CFG_BITS-1:0] DEBOUNCE_RESET = 16'd50;
    localparam logic [CFG_BITS-1:0] CLICK_RESET    = 16'd300;
    localparam logic [CFG_BITS-1:0] SETTING_RESET  = 16'd3000;
    localparam logic [CFG_BITS-1:0] FEEDING_RESET  = 16'd6000;
    localparam logic [CFG_BITS-1:0] DOUBLE_RESET   = 16'd400;

    localparam logic [IDX_BITS-1:0] REG_DEBOUNCE = 3'd0;
    localparam logic [IDX_BITS-1:0] REG_CLICK    = 3'd1;
    localparam logic [IDX_BITS-1:0] REG_SETTING  = 3'd2;
    localparam logic [IDX_BITS-1:0] REG_FEEDING  = 3'd3;
    localparam logic [IDX_BITS-1:0] REG_DOUBLE   = 3'd4;

    typedef enum logic [2:0] {
        EV_NONE    = 3'd0,
        EV_CLICK   = 3'd1,
        EV_DOUBLE  = 3'd2,
        EV_SETTING = 3'd3,
        EV_FEEDING = 3'd4,
        EV_STOP    = 3'd5
    } event_t;

    typedef struct packed {
        logic switch_level;
        logic feeding_active;
        logic take_event;
    } in_t;

    typedef struct packed {
        logic [2:0]          event_code;
        logic [DUR_BITS-1:0] press_duration;
    } out_t;

    typedef struct packed {
        logic [CFG_BITS-1:0] debounce_lim;
        logic [CFG_BITS-1:0] click_max_ms;
        logic [CFG_BITS-1:0] hold_setting_ms;
        logic [CFG_BITS-1:0] hold_feeding_ms;
        logic [CFG_BITS-1:0] double_click_ms;
    } cfg_t;

endpackage

[hdl/bgc_cfg_regs.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Button gesture classifier configuration registers
// Holds the five timing thresholds and decodes the plain write port.
// ----------------------------------------------------------------------------
module bgc_cfg_regs (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [bgc_pkg::IDX_BITS-1:0]  cfg_index,
    input  logic [bgc_pkg::CFG_BITS-1:0]  cfg_wdata,
    output bgc_pkg::cfg_t                 cfg
);
    import bgc_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            unique case (cfg_index)
                REG_DEBOUNCE: cfg_next.debounce_lim    = cfg_wdata;
                REG_CLICK:    cfg_next.click_max_ms    = cfg_wdata;
                REG_SETTING:  cfg_next.hold_setting_ms = cfg_wdata;
                REG_FEEDING:  cfg_next.hold_feeding_ms = cfg_wdata;
                REG_DOUBLE:   cfg_next.double_click_ms = cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.debounce_lim    <= DEBOUNCE_RESET;
            cfg_reg.click_max_ms    <= CLICK_RESET;
            cfg_reg.hold_setting_ms <= SETTING_RESET;
            cfg_reg.hold_feeding_ms <= FEEDING_RESET;
            cfg_reg.double_click_ms <= DOUBLE_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

[hdl/bgc_engine.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Button gesture classifier engine
// Debounce, press timing, gesture classification and the result register.
// ----------------------------------------------------------------------------
module bgc_engine #(
    parameter int TIMER_BITS = 16
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  bgc_pkg::cfg_t  cfg,
    input  logic           s_valid,
    output logic           s_ready,
    input  bgc_pkg::in_t   s_data,
    output logic           m_valid,
    input  logic           m_ready,
    output bgc_pkg::out_t  m_data
);
    import bgc_pkg::*;

    localparam int CW = (TIMER_BITS > CFG_BITS) ? TIMER_BITS : CFG_BITS;

    typedef logic [TIMER_BITS-1:0] timer_t;

    logic   last_reg, last_next;
    timer_t stable_reg, stable_next;
    logic   pressed_reg, pressed_next;
    timer_t press_reg, press_next;
    logic   await_reg, await_next;
    timer_t window_reg, window_next;
    event_t pending_reg, pending_next;
    logic   m_valid_reg;
    out_t   out_reg, out_next;
    logic   s_accept;
    logic   trusted;
    logic [CW-1:0] dur_ext;

    function automatic timer_t sat_inc(input timer_t t);
        return (&t) ? t : TIMER_BITS'(t + 1'b1);
    endfunction

    assign s_ready  = !m_valid_reg || m_ready;
    assign s_accept = s_valid && s_ready;

    always_comb begin
        press_next   = pressed_reg ? sat_inc(press_reg) : press_reg;
        window_next  = await_reg ? sat_inc(window_reg) : window_reg;
        pressed_next = pressed_reg;
        await_next   = await_reg;
        pending_next = pending_reg;
        last_next    = last_reg;
        out_next     = '0;

        if (s_data.switch_level != last_reg) begin
            last_next   = s_data.switch_level;
            stable_next = '0;
        end else begin
            stable_next = sat_inc(stable_reg);
        end

        trusted = CW'(stable_next) > CW'(cfg.debounce_lim);

        if (trusted) begin
            if (!last_next && !pressed_reg) begin
                pressed_next = 1'b1;
                press_next   = '0;
            end else if (!last_next) begin
                if (CW'(press_next) >= CW'(cfg.hold_feeding_ms) && pending_reg == EV_NONE) begin
                    pending_next = EV_FEEDING;
                end
            end else if (pressed_reg) begin
                pressed_next = 1'b0;
                if (CW'(press_next) < CW'(cfg.click_max_ms)) begin
                    if (await_reg && CW'(window_next) < CW'(cfg.double_click_ms)) begin
                        pending_next = EV_DOUBLE;
                        await_next   = 1'b0;
                    end else begin
                        await_next  = 1'b1;
                        window_next = '0;
                    end
                end else if (CW'(press_next) > CW'(cfg.hold_setting_ms)
                             && CW'(press_next) < CW'(cfg.hold_feeding_ms)) begin
                    if (pending_reg == EV_NONE) begin
                        pending_next = EV_SETTING;
                    end
                end else if (CW'(press_next) >= CW'(cfg.hold_feeding_ms)) begin
                    if (s_data.feeding_active) begin
                        pending_next = EV_STOP;
                    end
                end
            end
        end

        if (await_next && CW'(window_next) > CW'(cfg.double_click_ms)) begin
            await_next   = 1'b0;
            pending_next = EV_CLICK;
        end

        if (s_data.take_event) begin
            out_next.event_code = pending_next;
            pending_next        = EV_NONE;
        end

        dur_ext = pressed_next ? CW'(press_next) : '0;
        out_next.press_duration = (dur_ext > CW'({DUR_BITS{1'b1}})) ?
                                  {DUR_BITS{1'b1}} : dur_ext[DUR_BITS-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_reg    <= 1'b1;
            stable_reg  <= '0;
            pressed_reg <= 1'b0;
            press_reg   <= '0;
            await_reg   <= 1'b0;
            window_reg  <= '0;
            pending_reg <= EV_NONE;
            m_valid_reg <= 1'b0;
        end else begin
            if (s_accept) begin
                last_reg    <= last_next;
                stable_reg  <= stable_next;
                pressed_reg <= pressed_next;
                press_reg   <= press_next;
                await_reg   <= await_next;
                window_reg  <= window_next;
                pending_reg <= pending_next;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            out_reg <= out_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

`ifndef SYNTH
    a_no_event_without_take: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && !s_data.take_event |=> out_reg.event_code == EV_NONE)
        else $error("event reported without a take request");

    a_take_clears_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && s_data.take_event |=> pending_reg == EV_NONE)
        else $error("pending event survived a take request");

    a_released_zero_duration: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !pressed_reg |-> out_reg.press_duration == '0)
        else $error("nonzero press duration while released");
`endif

endmodule

[hdl/button_gesture_classifier_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Button gesture classifier core
// Debounces a switch and reports click, double click and hold gestures.
// ----------------------------------------------------------------------------
// Each request is one millisecond tick and yields exactly one result. A tick
// is classified by the combinational engine logic that lies between the state
// registers and the result register, so a new request is taken every cycle
// while the result register is empty or being drained. Timers are TIMER_BITS
// wide and saturate; the user must write thresholds through the plain write
// port only while no request is in flight, as the block does not enforce it.
module button_gesture_classifier_core #(
    parameter int TIMER_BITS = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [bgc_pkg::IDX_BITS-1:0]  cfg_index,
    input  logic [bgc_pkg::CFG_BITS-1:0]  cfg_wdata,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  bgc_pkg::in_t                  s_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output bgc_pkg::out_t                 m_data
);
    import bgc_pkg::*;

    cfg_t cfg;

    bgc_cfg_regs u_cfg_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    bgc_engine #(
        .TIMER_BITS (TIMER_BITS)
    ) u_engine (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

[tb/gesture_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gesture checker
// Watches the request, result and register ports of the gesture classifier,
// predicts every result from the requests it sees and compares it field by
// field with what the block returns, in order.
// ----------------------------------------------------------------------------
module gesture_checker (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_we,
    input  logic [bgc_pkg::IDX_BITS-1:0] cfg_index,
    input  logic [bgc_pkg::CFG_BITS-1:0] cfg_wdata,
    input  logic                         s_valid,
    input  logic                         s_ready,
    input  bgc_pkg::in_t                 s_data,
    input  logic                         m_valid,
    input  logic                         m_ready,
    input  bgc_pkg::out_t                m_data,
    output int                           mismatch_count,
    output int                           inflight
);
    import bgc_pkg::*;

    localparam int TICK_BITS   = 16;

    typedef logic [TICK_BITS-1:0] tick_t;

    cfg_t   thr;
    logic   prev_level;
    tick_t  steady_ticks;
    logic   held;
    tick_t  hold_ticks;
    logic   armed;
    tick_t  gap_ticks;
    event_t stored;
    out_t   gesture_due [$];

    function automatic tick_t bump(input tick_t t);
        return (t == '1) ? t : t + 1'b1;
    endfunction

    function automatic out_t classify_tick(input in_t req);
        out_t   res;
        event_t taken;
        taken = EV_NONE;
        if (held) begin
            hold_ticks = bump(hold_ticks);
        end
        if (armed) begin
            gap_ticks = bump(gap_ticks);
        end
        if (req.switch_level != prev_level) begin
            prev_level   = req.switch_level;
            steady_ticks = '0;
        end else begin
            steady_ticks = bump(steady_ticks);
        end
        if (steady_ticks > thr.debounce_lim) begin
            if (!prev_level && !held) begin
                held       = 1'b1;
                hold_ticks = '0;
            end else if (!prev_level) begin
                if (hold_ticks >= thr.hold_feeding_ms && stored == EV_NONE) begin
                    stored = EV_FEEDING;
                end
            end else if (held) begin
                if (hold_ticks < thr.click_max_ms) begin
                    if (armed && gap_ticks < thr.double_click_ms) begin
                        stored = EV_DOUBLE;
                        armed  = 1'b0;
                    end else begin
                        armed     = 1'b1;
                        gap_ticks = '0;
                    end
                end else if (hold_ticks > thr.hold_setting_ms &&
                             hold_ticks < thr.hold_feeding_ms) begin
                    if (stored == EV_NONE) begin
                        stored = EV_SETTING;
                    end
                end else if (hold_ticks >= thr.hold_feeding_ms) begin
                    if (req.feeding_active) begin
                        stored = EV_STOP;
                    end
                end
                held = 1'b0;
            end
        end
        // A lone click is only known once its double-click window has closed.
        if (armed && gap_ticks > thr.double_click_ms) begin
            armed  = 1'b0;
            stored = EV_CLICK;
        end
        if (req.take_event) begin
            taken  = stored;
            stored = EV_NONE;
        end
        res.event_code     = taken;
        res.press_duration = held ? hold_ticks : '0;
        return res;
    endfunction

    always @(posedge aclk) begin
        out_t due;
        if (!aresetn) begin
            thr.debounce_lim    = DEBOUNCE_RESET;
            thr.click_max_ms    = CLICK_RESET;
            thr.hold_setting_ms = SETTING_RESET;
            thr.hold_feeding_ms = FEEDING_RESET;
            thr.double_click_ms = DOUBLE_RESET;
            prev_level     = 1'b1;
            steady_ticks   = '0;
            held           = 1'b0;
            hold_ticks     = '0;
            armed          = 1'b0;
            gap_ticks      = '0;
            stored         = EV_NONE;
            gesture_due.delete();
            mismatch_count = 0;
            inflight       = 0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_DEBOUNCE: thr.debounce_lim    = cfg_wdata;
                    REG_CLICK:    thr.click_max_ms    = cfg_wdata;
                    REG_SETTING:  thr.hold_setting_ms = cfg_wdata;
                    REG_FEEDING:  thr.hold_feeding_ms = cfg_wdata;
                    REG_DOUBLE:   thr.double_click_ms = cfg_wdata;
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                if (gesture_due.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: result with no request pending, expected none, got %0d/%0d",
                             $time, m_data.event_code, m_data.press_duration);
                end else begin
                    due = gesture_due.pop_front();
                    if (m_data.event_code !== due.event_code) begin
                        mismatch_count++;
                        $display("%0t: event_code expected %0d, got %0d",
                                 $time, due.event_code, m_data.event_code);
                    end
                    if (m_data.press_duration !== due.press_duration) begin
                        mismatch_count++;
                        $display("%0t: press_duration expected %0d, got %0d",
                                 $time, due.press_duration, m_data.press_duration);
                    end
                end
            end
            if (s_valid && s_ready) begin
                gesture_due.push_back(classify_tick(s_data));
            end
            inflight = gesture_due.size();
        end
    end

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gesture classifier testbench
// Feeds millisecond ticks of switch level to the classifier under bursty
// request flow and a stalling result side, across default, small, zero and
// saturating threshold settings, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module tb;
    import bgc_pkg::*;

    localparam int LIMIT  = 3000000;
    localparam int NEVER  = 0;
    localparam int ALWAYS = 1;
    localparam int COIN   = 2;
    localparam logic [IDX_BITS-1:0] REG_ORDER [5] =
        '{REG_DEBOUNCE, REG_CLICK, REG_SETTING, REG_FEEDING, REG_DOUBLE};

    logic                aclk = 1'b0;
    logic                aresetn;
    logic                cfg_we;
    logic [IDX_BITS-1:0] cfg_index;
    logic [CFG_BITS-1:0] cfg_wdata;
    logic                s_valid;
    logic                s_ready;
    in_t                 s_data;
    logic                m_valid;
    logic                m_ready = 1'b0;
    out_t                m_data;

    int   mismatch_count;
    int   inflight;
    int   cycle_count = 0;
    int   ticks_sent  = 0;
    int   burst_left  = 0;
    int   rx_left     = 0;
    logic rx_open     = 1'b1;
    cfg_t cur;

    button_gesture_classifier_core #(.TIMER_BITS(16)) uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    gesture_checker chk (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_data         (s_data),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_data         (m_data),
        .mismatch_count (mismatch_count),
        .inflight       (inflight)
    );

    always #4 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // The result side alternates open and stalled stretches, with windows
    // in which it never stalls.
    always @(negedge aclk) begin
        if (rx_left == 0) begin
            rx_open = !rx_open;
            rx_left = rx_open ? $urandom_range(1, 30) : $urandom_range(1, 5);
        end
        rx_left--;
        m_ready <= rx_open || (((cycle_count >> 9) % 4) == 0);
    end

    function automatic logic pick(input int mode);
        return (mode == COIN) ? logic'($urandom_range(0, 1)) : (mode == ALWAYS);
    endfunction

    task automatic push_tick(input in_t t);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
        end
        burst_left--;
        s_valid <= 1'b1;
        s_data  <= t;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        ticks_sent++;
        @(negedge aclk);
    endtask

    task automatic run_level(input logic level, input int n, input int feed, input int take);
        in_t t;
        repeat (n) begin
            t.switch_level   = level;
            t.feeding_active = pick(feed);
            t.take_event     = pick(take);
            push_tick(t);
        end
    endtask

    task automatic quiesce();
        s_valid   <= 1'b0;
        burst_left = 0;
        while (inflight != 0) @(negedge aclk);
    endtask

    task automatic load_thresholds(input cfg_t c);
        logic [CFG_BITS-1:0] vals [5];
        quiesce();
        vals = '{c.debounce_lim, c.click_max_ms, c.hold_setting_ms,
                 c.hold_feeding_ms, c.double_click_ms};
        for (int i = 0; i < 5; i++) begin
            cfg_we    <= 1'b1;
            cfg_index <= REG_ORDER[i];
            cfg_wdata <= vals[i];
            @(negedge aclk);
        end
        cfg_we <= 1'b0;
        cur = c;
    endtask

    function automatic cfg_t random_thresholds();
        cfg_t c;
        c.debounce_lim    = CFG_BITS'($urandom_range(0, 3));
        c.click_max_ms    = CFG_BITS'($urandom_range(2, 12));
        c.hold_setting_ms = c.click_max_ms + CFG_BITS'($urandom_range(0, 15));
        c.hold_feeding_ms = c.hold_setting_ms + CFG_BITS'($urandom_range(1, 15));
        if ($urandom_range(0, 5) == 0) begin
            c.hold_feeding_ms = CFG_BITS'($urandom_range(1, int'(c.hold_setting_ms)));
        end
        c.double_click_ms = CFG_BITS'($urandom_range(1, 20));
        return c;
    endfunction

    task automatic random_gesture();
        int kind;
        int db;
        kind = $urandom_range(0, 9);
        db   = int'(cur.debounce_lim);
        case (kind)
            0, 1, 2, 3: begin
                run_level(1'b0, db + 1 + $urandom_range(0, int'(cur.click_max_ms) + 1),
                          COIN, COIN);
                run_level(1'b1, db + 1 + $urandom_range(0, int'(cur.double_click_ms) + 2),
                          COIN, COIN);
            end
            4, 5, 6: begin
                run_level(1'b0, db + 1 + $urandom_range(int'(cur.hold_setting_ms),
                                                       int'(cur.hold_feeding_ms) + 4),
                          COIN, COIN);
                run_level(1'b1, db + 2 + $urandom_range(0, 3), COIN, COIN);
            end
            7: begin
                run_level(1'b0, db + 1 + $urandom_range(int'(cur.click_max_ms),
                                                       int'(cur.hold_setting_ms) + 1),
                          COIN, COIN);
                run_level(1'b1, db + 2, COIN, COIN);
            end
            default: begin
                repeat ($urandom_range(1, 6)) begin
                    run_level(logic'($urandom_range(0, 1)), $urandom_range(1, 3), COIN, COIN);
                end
            end
        endcase
    endtask

    initial begin
        int target;
        aresetn   = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = REG_DEBOUNCE;
        cfg_wdata = '0;
        s_valid   = 1'b0;
        s_data    = '0;
        cur = {DEBOUNCE_RESET, CLICK_RESET, SETTING_RESET, FEEDING_RESET, DOUBLE_RESET};
        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Thresholds straight out of reset: a press just past the debounce time.
        run_level(1'b1, 4, COIN, COIN);
        run_level(1'b0, 60, COIN, COIN);
        run_level(1'b1, 5, COIN, COIN);

        // Directed gestures under small thresholds.
        load_thresholds({16'd0, 16'd3, 16'd5, 16'd8, 16'd8});
        run_level(1'b1, 3, NEVER, ALWAYS);
        run_level(1'b0, 2, NEVER, ALWAYS);
        run_level(1'b1, 12, NEVER, ALWAYS);
        run_level(1'b0, 2, NEVER, ALWAYS);
        run_level(1'b1, 2, NEVER, ALWAYS);
        run_level(1'b0, 2, NEVER, ALWAYS);
        run_level(1'b1, 4, NEVER, ALWAYS);
        run_level(1'b0, 4, NEVER, ALWAYS);
        run_level(1'b1, 3, NEVER, ALWAYS);
        run_level(1'b0, 6, NEVER, ALWAYS);
        run_level(1'b1, 3, NEVER, NEVER);
        run_level(1'b1, 1, NEVER, ALWAYS);
        run_level(1'b0, 12, ALWAYS, ALWAYS);
        run_level(1'b1, 3, ALWAYS, ALWAYS);

        load_thresholds('0);
        repeat (8) random_gesture();

        // Nothing is ever trusted with the longest debounce time.
        load_thresholds('1);
        run_level(1'b0, 10, COIN, COIN);
        run_level(1'b1, 10, COIN, COIN);
        repeat (6) run_level(logic'($urandom_range(0, 1)), $urandom_range(1, 3), COIN, COIN);

        // A click under the widest double-click window, a medium press, then
        // a second click while that window is still open.
        load_thresholds({16'd1, 16'd10, 16'hFFFF, 16'hFFFF, 16'hFFFF});
        run_level(1'b1, 4, COIN, COIN);
        run_level(1'b0, 5, COIN, COIN);
        run_level(1'b1, 6, COIN, COIN);
        run_level(1'b0, 60, NEVER, COIN);
        run_level(1'b1, 4, ALWAYS, ALWAYS);
        run_level(1'b0, 5, COIN, COIN);
        run_level(1'b1, 6, COIN, COIN);

        target = 850;
        while (ticks_sent < target) begin
            load_thresholds(random_thresholds());
            repeat ($urandom_range(6, 14)) random_gesture();
            if ($urandom_range(0, 3) == 0) begin
                quiesce();
            end
        end

        quiesce();
        repeat (16) @(negedge aclk);
        if (mismatch_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
